>>> design/fhp_pkg.sv
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types, byte codes and helpers of the format header probe.
// ----------------------------------------------------------------------------
package fhp_pkg;

  // Offsets saturate at the buffer bound; the bound fits in POS_W bits.
  localparam int unsigned MAX_BUFFER_BYTES = 1048576;
  localparam int unsigned POS_W            = 21;
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_BUFFER_BYTES);

  localparam int unsigned KEY_LEN = 6;
  localparam int unsigned KEY_W   = 3;

  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISSING     = 3'd1,
    ST_NOT_FIRST   = 3'd2,
    ST_BARE_KEY    = 3'd3,
    ST_EQUALS      = 3'd4,
    ST_INVALID     = 3'd5,
    ST_UNSUPPORTED = 3'd6
  } fhp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } fhp_item_t;

  typedef struct packed {
    fhp_status_e      status;
    logic             version;
    logic [POS_W-1:0] span_begin;
    logic [POS_W-1:0] span_end;
  } fhp_result_t;

  // Characters of the bare key "format"
  function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h6D;
      3'd4:    c = 8'h61;
      3'd5:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] p);
    return (p < POS_MAX) ? p + POS_W'(1) : POS_MAX;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return (b == CH_HASH) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

>>> design/fhp_if.sv
// ----------------------------------------------------------------------------
// fhp_if
// Valid/ready channels of the format header probe: byte stream in, verdict out.
// ----------------------------------------------------------------------------
interface fhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

interface fhp_out_if
  import fhp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic             version;
  logic [POS_W-1:0] span_begin;
  logic [POS_W-1:0] span_end;

  modport source (output valid, output status, output version, output span_begin,
                  output span_end, input ready);
  modport sink   (input valid, input status, input version, input span_begin,
                  input span_end, output ready);
endinterface

>>> design/fhp_parser.sv
// ----------------------------------------------------------------------------
// fhp_parser
// Per-byte scanner of the header declaration; one item per step, at most
// one verdict per buffer, all state but decl_q/vstart_q reset on last items.
// ----------------------------------------------------------------------------
module fhp_parser
  import fhp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  fhp_item_t   item_i,
  output logic        res_valid_o,
  output fhp_result_t res_o
);

  typedef enum logic [3:0] {
    PH_BOM0    = 4'd0,
    PH_BOM1    = 4'd1,
    PH_BOM2    = 4'd2,
    PH_SKIP    = 4'd3,
    PH_COMMENT = 4'd4,
    PH_KEY     = 4'd5,
    PH_KEYEND  = 4'd6,
    PH_PREEQ   = 4'd7,
    PH_POSTEQ  = 4'd8,
    PH_VALUE   = 4'd9,
    PH_TRAIL   = 4'd10
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] decl_q, decl_d;
  logic [POS_W-1:0] vstart_q, vstart_d;
  logic [KEY_W-1:0] key_idx_q, key_idx_d;
  logic [1:0]       len_q, len_d;
  logic             fdz_q, fdz_d;
  logic             fco_q, fco_d;
  logic             alldig_q, alldig_d;
  logic             done_q, done_d;
  logic             emit;
  fhp_result_t      res;
  logic [7:0]       b;

  function automatic fhp_result_t mk(input fhp_status_e st, input logic [POS_W-1:0] sb,
                                     input logic [POS_W-1:0] se);
    fhp_result_t r;
    r.status     = st;
    r.version    = 1'b0;
    r.span_begin = sb;
    r.span_end   = se;
    return r;
  endfunction

  function automatic fhp_result_t judge(input logic [1:0] len, input logic fco,
                                        input logic fdz, input logic alldig,
                                        input logic [POS_W-1:0] vs,
                                        input logic [POS_W-1:0] e);
    fhp_result_t r;
    if (len == 2'd1 && fco) begin
      r = mk(ST_OK, '0, '0);
      r.version = 1'b1;
    end else if (len != 2'd0 && alldig && (len == 2'd1 || !fdz)) begin
      r = mk(ST_UNSUPPORTED, vs, e);
    end else begin
      r = mk(ST_INVALID, vs, e);
    end
    return r;
  endfunction

  assign b = item_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    decl_d    = decl_q;
    vstart_d  = vstart_q;
    key_idx_d = key_idx_q;
    len_d     = len_q;
    fdz_d     = fdz_q;
    fco_d     = fco_q;
    alldig_d  = alldig_q;
    done_d    = done_q;
    emit      = 1'b0;
    res       = mk(ST_NOT_FIRST, '0, POS_W'(1));

    // byte part
    if (item_i.byte_valid && !done_q) begin
      unique case (phase_q)
        PH_BOM0, PH_SKIP: begin
          if (phase_q == PH_BOM0 && b == CH_BOM0) begin
            phase_d = PH_BOM1;
          end else if (is_blank(b) || b == CH_CR || b == CH_LF) begin
            phase_d = PH_SKIP;
          end else if (b == CH_HASH) begin
            phase_d = PH_COMMENT;
          end else begin
            decl_d = pos_q;
            if (b == key_char('0)) begin
              key_idx_d = KEY_W'(1);
              phase_d   = PH_KEY;
            end else begin
              emit = 1'b1;
              res  = mk(ST_NOT_FIRST, pos_q, sat_next(pos_q));
            end
          end
        end
        PH_BOM1: begin
          if (b == CH_BOM1) phase_d = PH_BOM2;
          else emit = 1'b1;
        end
        PH_BOM2: begin
          if (b == CH_BOM2) phase_d = PH_SKIP;
          else emit = 1'b1;
        end
        PH_COMMENT: begin
          if (b == CH_LF) phase_d = PH_SKIP;
        end
        PH_KEY: begin
          if (key_idx_q < KEY_W'(KEY_LEN) && b == key_char(key_idx_q)) begin
            key_idx_d = key_idx_q + KEY_W'(1);
            if (key_idx_d >= KEY_W'(KEY_LEN)) phase_d = PH_KEYEND;
          end else begin
            emit = 1'b1;
            res  = mk(ST_NOT_FIRST, decl_q, sat_next(decl_q));
          end
        end
        PH_KEYEND, PH_PREEQ: begin
          if (is_blank(b)) begin
            phase_d = PH_PREEQ;
          end else if (b == CH_EQ) begin
            phase_d = PH_POSTEQ;
          end else begin
            emit = 1'b1;
            if (phase_q == PH_KEYEND) res = mk(ST_BARE_KEY, decl_q, sat_next(pos_q));
            else                      res = mk(ST_EQUALS, decl_q, pos_q);
          end
        end
        PH_POSTEQ: begin
          if (!is_blank(b)) begin
            vstart_d = pos_q;
            if (is_term(b)) begin
              len_d = 2'd0;
              emit  = 1'b1;
              res   = judge(2'd0, fco_q, fdz_q, alldig_q, pos_q, pos_q);
            end else begin
              len_d    = 2'd1;
              fdz_d    = (b == CH_ZERO);
              fco_d    = (b == CH_ONE);
              alldig_d = is_digit(b);
              phase_d  = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          if (is_blank(b)) begin
            phase_d = PH_TRAIL;
          end else if (is_term(b)) begin
            emit = 1'b1;
            res  = judge(len_q, fco_q, fdz_q, alldig_q, vstart_q, pos_q);
          end else begin
            len_d    = 2'd2;
            alldig_d = alldig_q && is_digit(b);
          end
        end
        PH_TRAIL: begin
          if (is_term(b)) begin
            emit = 1'b1;
            res  = judge(len_q, fco_q, fdz_q, alldig_q, vstart_q, pos_q);
          end else if (!is_blank(b)) begin
            emit = 1'b1;
            res  = mk(ST_INVALID, vstart_q, sat_next(pos_q));
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
    if (item_i.byte_valid) pos_d = sat_next(pos_q);
    if (emit) done_d = 1'b1;

    // end of buffer, judged on the state left by the byte part
    if (item_i.last && !done_d) begin
      emit = 1'b1;
      unique case (phase_d)
        PH_BOM0, PH_SKIP, PH_COMMENT: res = mk(ST_MISSING, pos_d, pos_d);
        PH_BOM1, PH_BOM2:             res = mk(ST_NOT_FIRST, '0, POS_W'(1));
        PH_KEY:                       res = mk(ST_NOT_FIRST, decl_d, sat_next(decl_d));
        PH_KEYEND, PH_PREEQ:          res = mk(ST_EQUALS, decl_d, pos_d);
        PH_POSTEQ:                    res = judge(2'd0, fco_d, fdz_d, alldig_d, pos_d, pos_d);
        PH_VALUE, PH_TRAIL:           res = judge(len_d, fco_d, fdz_d, alldig_d, vstart_d,
                                                  pos_d);
        default:                      res = mk(ST_NOT_FIRST, '0, POS_W'(1));
      endcase
    end

    // back to the initial state for the next buffer
    if (item_i.last) begin
      phase_d   = PH_BOM0;
      pos_d     = '0;
      key_idx_d = '0;
      len_d     = '0;
      fdz_d     = 1'b0;
      fco_d     = 1'b0;
      alldig_d  = 1'b1;
      done_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BOM0;
      pos_q     <= '0;
      decl_q    <= '0;
      vstart_q  <= '0;
      key_idx_q <= '0;
      len_q     <= '0;
      fdz_q     <= 1'b0;
      fco_q     <= 1'b0;
      alldig_q  <= 1'b1;
      done_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      decl_q    <= decl_d;
      vstart_q  <= vstart_d;
      key_idx_q <= key_idx_d;
      len_q     <= len_d;
      fdz_q     <= fdz_d;
      fco_q     <= fco_d;
      alldig_q  <= alldig_d;
      done_q    <= done_d;
    end
  end

  assign res_valid_o = step_i && emit;
  assign res_o       = res;

endmodule

>>> design/format_header_probe_top.sv
// ----------------------------------------------------------------------------
// format_header_probe_top
// Checks the leading "format = <value>" declaration of a byte stream and
// reports one verdict per buffer.
// ----------------------------------------------------------------------------
//   channel    dir  payload                                      transfer when
//   byte_i     in   data_byte, byte_valid, last                  valid && ready
//   verdict_o  out  status, version, span_begin, span_end        valid && ready
//
// One byte per cycle sustained while verdict_o is not stalled. A byte goes
// input register -> scanner -> verdict register; the verdict register loads
// when the scanner steps on the held byte and emits. The scanner state is
// registered and advances whenever a byte is held and the verdict register
// is empty or being drained. Reset clears all control state; scanner state
// but decl_q/vstart_q returns to initial values after every item marked last.
module format_header_probe_top
  import fhp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fhp_in_if.sink     byte_i,
  fhp_out_if.source  verdict_o
);

  logic        in_valid_q;
  fhp_item_t   item_q;
  logic        out_valid_q;
  fhp_result_t out_q;
  logic        advance;
  logic        step;
  logic        res_valid;
  fhp_result_t res;

  assign advance      = !out_valid_q || verdict_o.ready;
  assign step         = in_valid_q && advance;
  assign byte_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      item_q.data_byte  <= byte_i.data_byte;
      item_q.byte_valid <= byte_i.byte_valid;
      item_q.last       <= byte_i.last;
    end
  end

  fhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign verdict_o.valid      = out_valid_q;
  assign verdict_o.status     = out_q.status;
  assign verdict_o.version    = out_q.version;
  assign verdict_o.span_begin = out_q.span_begin;
  assign verdict_o.span_end   = out_q.span_end;

`ifndef ASSERT_OFF
  a_new_verdict_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step))
    else $error("verdict appeared without a scanner step");

  a_hold_pending_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("pending byte lost while output stalled");

  a_ok_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_OK |->
      out_q.version && out_q.span_begin == '0 && out_q.span_end == '0)
    else $error("ok verdict with bad version or span");

  a_err_no_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> !out_q.version)
    else $error("error verdict carries a version");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.span_begin <= out_q.span_end)
    else $error("span begins after it ends");
`endif

endmodule
